@@ rtl/salc_pkg.sv @@
// salc_pkg: constants, opcodes, register indexes and helpers for the lru cache model
// no dependencies; used by set_assoc_lru_cache_model_unit
package salc_pkg;

   localparam int OPCODE_W   = 2;
   localparam int REQ_ADDR_W = 64;
   localparam int REQ_DATA_W = 72;
   localparam int TOTAL_W    = 32;
   localparam int RSP_DATA_W = 104;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_STORE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_MODIFY = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WAYS_IN_USE = 2'd2;

   localparam logic [2:0] SET_BITS_RESET    = 3'd4;
   localparam logic [4:0] OFFSET_BITS_RESET = 5'd4;
   localparam logic [3:0] WAYS_RESET        = 4'd1;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // saturating add of a small count to a running total
   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] v,
                                                  input logic [1:0] n);
      logic [TOTAL_W:0] s;
      s = {1'b0, v} + {{(TOTAL_W - 1){1'b0}}, n};
      return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
   endfunction

endpackage

@@ rtl/salc_ram.sv @@
// salc_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/set_assoc_lru_cache_model_unit.sv @@
// set_assoc_lru_cache_model_unit: tag store of a set-associative lru cache with hit/miss counters
// depends on salc_pkg and salc_ram (one row of all ways per set)
//
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tdata: opcode, address
//  rsp     | out | rsp_tvalid/tready   | tdata: hits_now, missed_now, evicted_now, 3 totals
//  csr     | in  | csr_we              | csr_addr, csr_wdata
//
// per request, the set row is read from the ram in the accept cycle, then looked up, aged
// and written back in the update state, which also loads the result; a new request is only
// taken after that; the update waits while an earlier result is still held on rsp
// reset: synchronous; clears the per-set init flags so every set reads as empty, no sweep
// csr writes take effect at the next clock edge
module set_assoc_lru_cache_model_unit #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [salc_pkg::REQ_DATA_W-1:0]    req_tdata,   // opcode, address, zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [salc_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // hits_now, missed_now,
                                                           // evicted_now, hit_total,
                                                           // miss_total, eviction_total, pad
   input  logic                               csr_we,
   input  logic [salc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [salc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SETS    = 1 << MAX_SET_BITS;
   localparam int SET_W   = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
   localparam int AGE_W   = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_W   = 1 + AGE_W + ADDR_WIDTH;
   localparam int ROW_W   = MAX_WAYS * WAY_W;
   localparam int SB_W    = 4;
   localparam int NW_W    = 5;
   localparam int TW      = salc_pkg::TOTAL_W;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_UPDATE = 1'b1;

   // configuration
   logic [2:0] set_bits_ff;
   logic [4:0] offset_bits_ff;
   logic [3:0] ways_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= salc_pkg::SET_BITS_RESET;
         offset_bits_ff <= salc_pkg::OFFSET_BITS_RESET;
         ways_ff        <= salc_pkg::WAYS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            salc_pkg::CSR_SET_BITS:    set_bits_ff    <= csr_wdata[2:0];
            salc_pkg::CSR_OFFSET_BITS: offset_bits_ff <= csr_wdata;
            salc_pkg::CSR_WAYS_IN_USE: ways_ff        <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   logic [SB_W-1:0] sb;
   logic [NW_W-1:0] nways;

   always_comb begin
      sb = ({1'b0, set_bits_ff} > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
                                                       : SB_W'(set_bits_ff);
      if (ways_ff == 4'd0) begin
         nways = NW_W'(1);
      end else if ({1'b0, ways_ff} > NW_W'(MAX_WAYS)) begin
         nways = NW_W'(MAX_WAYS);
      end else begin
         nways = NW_W'(ways_ff);
      end
   end

   // request decode
   logic [salc_pkg::OPCODE_W-1:0] req_op;
   logic [ADDR_WIDTH-1:0]         req_addr;
   logic [ADDR_WIDTH-1:0]         addr_sh;
   logic [SET_W-1:0]              req_set;
   logic [ADDR_WIDTH-1:0]         req_tag;
   logic                          req_fire;

   assign req_op   = req_tdata[salc_pkg::OPCODE_W-1:0];
   assign req_addr = req_tdata[salc_pkg::OPCODE_W +: ADDR_WIDTH];
   assign addr_sh  = req_addr >> offset_bits_ff;
   assign req_set  = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
   assign req_tag  = addr_sh >> sb;

   // control
   logic                          state_ff, state_in;
   logic [salc_pkg::OPCODE_W-1:0] op_ff;
   logic [SET_W-1:0]              set_ff;
   logic [ADDR_WIDTH-1:0]         tag_ff;
   logic [SETS-1:0]               row_init_ff;
   logic                          rsp_valid_ff;
   logic [salc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [TW-1:0]                 hits_sum_ff, hits_sum_in;
   logic [TW-1:0]                 misses_sum_ff, misses_sum_in;
   logic [TW-1:0]                 evict_sum_ff, evict_sum_in;
   logic                          upd_fire;
   logic                          access_en;
   logic                          ram_we;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign upd_fire   = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_tready);
   assign access_en  = (op_ff == salc_pkg::OP_LOAD) || (op_ff == salc_pkg::OP_STORE) ||
                       (op_ff == salc_pkg::OP_MODIFY);
   assign ram_we     = upd_fire && access_en;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_UPDATE;
         ST_UPDATE: if (upd_fire) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // set row storage
   logic [ROW_W-1:0] row_rd, row_wr;

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (set_ff),
      .wr_data (row_wr),
      .rd_en   (req_fire),
      .rd_addr (req_set),
      .rd_data (row_rd)
   );

   // lookup and lru update
   logic [MAX_WAYS-1:0]   way_used, way_valid, hit_vec, hit_first, empty_vec, victim_vec;
   logic [MAX_WAYS-1:0]   tgt_vec;
   logic [AGE_W-1:0]      way_age [MAX_WAYS];
   logic [ADDR_WIDTH-1:0] way_tag [MAX_WAYS];
   logic [AGE_W-1:0]      victim_age, tgt_age;
   logic                  tgt_valid, hit, have_empty;
   logic [1:0]            hits_now;
   logic                  missed_now, evicted_now;

   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         way_used[i]  = NW_W'(i) < nways;
         way_valid[i] = row_init_ff[set_ff] && row_rd[i*WAY_W + WAY_W - 1];
         way_age[i]   = row_init_ff[set_ff] ? row_rd[i*WAY_W + ADDR_WIDTH +: AGE_W]
                                            : '0;
         way_tag[i]   = row_rd[i*WAY_W +: ADDR_WIDTH];
         hit_vec[i]   = way_used[i] && way_valid[i] && (way_tag[i] == tag_ff);
      end

      hit_first = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_first    = '0;
            hit_first[i] = 1'b1;
         end
      end

      empty_vec = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (way_used[i] && !way_valid[i]) begin
            empty_vec    = '0;
            empty_vec[i] = 1'b1;
         end
      end

      victim_vec    = '0;
      victim_vec[0] = 1'b1;
      victim_age    = way_age[0];
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (way_used[i] && (way_age[i] > victim_age)) begin
            victim_vec    = '0;
            victim_vec[i] = 1'b1;
            victim_age    = way_age[i];
         end
      end

      hit        = |hit_vec;
      have_empty = |empty_vec;
      priority if (hit)   tgt_vec = hit_first;
      else if (have_empty) tgt_vec = empty_vec;
      else                tgt_vec = victim_vec;

      tgt_valid = |(tgt_vec & way_valid);
      tgt_age   = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (tgt_vec[i]) tgt_age = tgt_age | way_age[i];
      end

      for (int i = 0; i < MAX_WAYS; i++) begin
         if (tgt_vec[i]) begin
            row_wr[i*WAY_W +: WAY_W] = {1'b1, AGE_W'(0), tag_ff};
         end else if (way_used[i] && way_valid[i] && (!tgt_valid || way_age[i] < tgt_age)
                      && ({1'b0, way_age[i]} < (AGE_W + 1)'(MAX_WAYS - 1))) begin
            row_wr[i*WAY_W +: WAY_W] = {1'b1, way_age[i] + AGE_W'(1), way_tag[i]};
         end else begin
            row_wr[i*WAY_W +: WAY_W] = {way_valid[i], way_age[i], way_tag[i]};
         end
      end

      missed_now  = access_en && !hit;
      evicted_now = missed_now && !have_empty;
      hits_now    = {1'b0, access_en && hit} +
                    {1'b0, op_ff == salc_pkg::OP_MODIFY};

      hits_sum_in   = salc_pkg::sat_add(hits_sum_ff, hits_now);
      misses_sum_in = salc_pkg::sat_add(misses_sum_ff, {1'b0, missed_now});
      evict_sum_in  = salc_pkg::sat_add(evict_sum_ff, {1'b0, evicted_now});
      rsp_data_in   = {4'd0, evict_sum_in, misses_sum_in, hits_sum_in,
                       evicted_now, missed_now, hits_now};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_init_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         hits_sum_ff   <= '0;
         misses_sum_ff <= '0;
         evict_sum_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (ram_we) begin
            row_init_ff[set_ff] <= 1'b1;
         end
         if (upd_fire) begin
            rsp_valid_ff  <= 1'b1;
            hits_sum_ff   <= hits_sum_in;
            misses_sum_ff <= misses_sum_in;
            evict_sum_ff  <= evict_sum_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_op;
         set_ff <= req_set;
         tag_ff <= req_tag;
      end
      if (upd_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_UPDATE)
      else $error("accepted request did not enter update");

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_UPDATE)
      else $error("row write outside update");

   a_one_target: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> $onehot(tgt_vec))
      else $error("update target not a single way");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_UPDATE)
      else $error("response raised without update");

   a_hits_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> hits_sum_ff >= $past(hits_sum_ff))
      else $error("hit total decreased");

endmodule
